/* rtl/sfsw_pkg.sv */
// Shared types and constants of the stuffed-frame stop-and-wait receiver.
// The link bytes, control codes, event codes and the result record live here.
// No dependencies.
package sfsw_pkg;

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] STUFF_MASK = 8'h20;

	localparam logic [7:0] CTL_SET    = 8'b0000_0011;
	localparam logic [7:0] CTL_DISC   = 8'b0000_1011;
	localparam logic [7:0] CTL_UA     = 8'b0000_0111;
	localparam logic [7:0] CTL_I_SEQ0 = 8'b0000_0000;
	localparam logic [7:0] CTL_I_SEQ1 = 8'b0100_0000;
	localparam logic [7:0] CTL_RR     = 8'b0000_0101;
	localparam logic [7:0] CTL_REJ    = 8'b0000_0001;
	localparam logic [7:0] R_BIT      = 8'b1000_0000;

	localparam logic [7:0] RX_ADDRESS_RST    = 8'd3;
	localparam logic [7:0] REPLY_ADDRESS_RST = 8'd1;

	// configuration register indexes
	localparam logic CFG_RX_ADDRESS    = 1'b0;
	localparam logic CFG_REPLY_ADDRESS = 1'b1;

	typedef enum logic [2:0] {
		EV_PAYLOAD  = 3'd0,
		EV_GOOD     = 3'd1,
		EV_BCC2_ERR = 3'd2,
		EV_DUP      = 3'd3,
		EV_SET      = 3'd4,
		EV_DISC     = 3'd5,
		EV_UA       = 3'd6
	} sfsw_event_t;

	typedef struct packed {
		sfsw_event_t ev;
		logic [7:0]  payload;
		logic        reply_valid;
		logic [7:0]  reply_control;
		logic [7:0]  reply_bcc;
		logic        seq_now;
	} sfsw_result_t;

endpackage

/* rtl/sfsw_frame_fsm.sv */
// Frame parser: flag hunt, header check, destuffing, BCC2 check and reply choice.
// Processes one byte per step and holds the frame state. Depends on sfsw_pkg.
module sfsw_frame_fsm import sfsw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   byte_in,
	input  logic [7:0]   rx_address,
	input  logic [7:0]   reply_address,
	output logic         res_valid,
	output sfsw_result_t res
);

	typedef enum logic [2:0] {
		PH_HUNT, PH_ADDR, PH_CTRL, PH_BCC1, PH_DATA, PH_SEND
	} phase_t;

	typedef enum logic [2:0] {
		KIND_NONE, KIND_SET, KIND_DISC, KIND_UA, KIND_INEW, KIND_IDUP
	} kind_t;

	phase_t     phase_q, phase_d;
	kind_t      kind_q, kind_d;
	logic       seq_q, seq_d;
	logic [7:0] held_q, held_d;
	logic       held_vld_q, held_vld_d;
	logic       esc_q, esc_d;
	logic [7:0] xor_q, xor_d;

	logic [7:0] ctl;
	logic [7:0] data_byte;
	logic [7:0] i_new_ctl;
	logic [7:0] i_dup_ctl;
	logic       bcc_ok;

	assign i_new_ctl = seq_q ? CTL_I_SEQ1 : CTL_I_SEQ0;
	assign i_dup_ctl = seq_q ? CTL_I_SEQ0 : CTL_I_SEQ1;
	assign bcc_ok    = held_vld_q && !esc_q && (held_q == xor_q);
	assign data_byte = esc_q ? (byte_in ^ STUFF_MASK) : byte_in;

	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		seq_d      = seq_q;
		held_d     = held_q;
		held_vld_d = held_vld_q;
		esc_d      = esc_q;
		xor_d      = xor_q;
		res_valid  = 1'b0;
		ctl        = 8'h00;
		res        = '0;
		res.ev     = EV_PAYLOAD;

		unique case (phase_q)
			PH_ADDR: begin
				if (byte_in != FLAG_BYTE) begin
					if (byte_in == rx_address) begin
						xor_d   = byte_in;
						phase_d = PH_CTRL;
					end else begin
						phase_d = PH_HUNT;
						kind_d  = KIND_NONE;
					end
				end
			end
			PH_CTRL: begin
				phase_d = PH_BCC1;
				xor_d   = xor_q ^ byte_in;
				if (byte_in == CTL_SET)        kind_d = KIND_SET;
				else if (byte_in == CTL_DISC)  kind_d = KIND_DISC;
				else if (byte_in == CTL_UA)    kind_d = KIND_UA;
				else if (byte_in == i_new_ctl) kind_d = KIND_INEW;
				else if (byte_in == i_dup_ctl) kind_d = KIND_IDUP;
				else begin
					// bad control: drop, a flag reopens
					xor_d   = xor_q;
					kind_d  = KIND_NONE;
					phase_d = (byte_in == FLAG_BYTE) ? PH_ADDR : PH_HUNT;
				end
			end
			PH_BCC1: begin
				if (byte_in != xor_q) begin
					kind_d  = KIND_NONE;
					phase_d = (byte_in == FLAG_BYTE) ? PH_ADDR : PH_HUNT;
				end else if (kind_q == KIND_INEW || kind_q == KIND_IDUP) begin
					xor_d      = 8'h00;
					held_vld_d = 1'b0;
					held_d     = 8'h00;
					esc_d      = 1'b0;
					phase_d    = PH_DATA;
				end else begin
					phase_d = PH_SEND;
				end
			end
			PH_SEND: begin
				kind_d = KIND_NONE;
				if (byte_in != FLAG_BYTE) begin
					phase_d = PH_HUNT;
				end else begin
					phase_d   = PH_ADDR;
					res_valid = 1'b1;
					case (kind_q)
						KIND_SET: begin
							res.ev          = EV_SET;
							res.reply_valid = 1'b1;
							ctl             = CTL_UA;
						end
						KIND_DISC: begin
							res.ev          = EV_DISC;
							res.reply_valid = 1'b1;
							ctl             = CTL_DISC;
						end
						default: res.ev = EV_UA;
					endcase
				end
			end
			PH_DATA: begin
				if (byte_in == FLAG_BYTE) begin
					phase_d         = PH_ADDR;
					kind_d          = KIND_NONE;
					held_vld_d      = 1'b0;
					esc_d           = 1'b0;
					res_valid       = 1'b1;
					res.reply_valid = 1'b1;
					if (kind_q == KIND_IDUP) begin
						res.ev = EV_DUP;
						ctl    = CTL_RR | (seq_q ? R_BIT : 8'h00);
					end else if (bcc_ok) begin
						seq_d  = ~seq_q;
						res.ev = EV_GOOD;
						ctl    = CTL_RR | (seq_q ? 8'h00 : R_BIT);
					end else begin
						res.ev = EV_BCC2_ERR;
						ctl    = CTL_REJ | (seq_q ? R_BIT : 8'h00);
					end
				end else if (!esc_q && byte_in == ESC_BYTE) begin
					esc_d = 1'b1;
				end else begin
					esc_d      = 1'b0;
					held_d     = data_byte;
					held_vld_d = 1'b1;
					// release the previous byte; it is known not to be BCC2
					if (held_vld_q && kind_q == KIND_INEW) begin
						xor_d       = xor_q ^ held_q;
						res_valid   = 1'b1;
						res.ev      = EV_PAYLOAD;
						res.payload = held_q;
					end
				end
			end
			default: begin
				kind_d  = KIND_NONE;
				phase_d = (byte_in == FLAG_BYTE) ? PH_ADDR : PH_HUNT;
			end
		endcase

		res.reply_control = res.reply_valid ? ctl : 8'h00;
		res.reply_bcc     = res.reply_valid ? (reply_address ^ ctl) : 8'h00;
		res.seq_now       = seq_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			kind_q     <= KIND_NONE;
			seq_q      <= 1'b0;
			held_q     <= 8'h00;
			held_vld_q <= 1'b0;
			esc_q      <= 1'b0;
			xor_q      <= 8'h00;
		end else if (step) begin
			phase_q    <= phase_d;
			kind_q     <= kind_d;
			seq_q      <= seq_d;
			held_q     <= held_d;
			held_vld_q <= held_vld_d;
			esc_q      <= esc_d;
			xor_q      <= xor_d;
		end
	end

endmodule

/* rtl/sfsw_out_stage.sv */
// Result register with valid/ready toward the consumer.
// Loads a result record while the consumer may still be taking the previous one.
// Depends on sfsw_pkg.
module sfsw_out_stage import sfsw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  sfsw_result_t res_in,
	output logic         free,
	output logic         out_valid,
	input  logic         out_ready,
	output sfsw_result_t res_out
);

	logic         valid_q;
	sfsw_result_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res_in;
		end
	end

endmodule

/* rtl/stuffed_frame_stop_and_wait_receiver.sv */
// Top level of the stuffed-frame stop-and-wait receiver: input register,
// configuration registers, frame parser and result register.
// Depends on sfsw_pkg, sfsw_frame_fsm and sfsw_out_stage.
//
//   channel   signals                               direction
//   in        in_valid, in_ready, rx_byte           request into the block
//   out       out_valid, out_ready, event_res,      result request out of the block
//             payload_byte, reply_valid,
//             reply_control, reply_bcc, seq_now
//   cfg       cfg_valid, cfg_ready, cfg_index,      register write, always ready
//             cfg_data
//
// One byte per cycle unless the result register is full and stalled; each byte is
// held in the input register, then the parser writes the result register.
// The parser state advances only when the byte in the input register leaves it.
// A byte that gives a result waits while the result register is full and stalled;
// a byte that gives none passes regardless. Reset loads addresses 3 and 1.
module stuffed_frame_stop_and_wait_receiver import sfsw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_res,
	output logic [7:0] payload_byte,
	output logic       reply_valid,
	output logic [7:0] reply_control,
	output logic [7:0] reply_bcc,
	output logic       seq_now,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0]   rx_address_q;
	logic [7:0]   reply_address_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         advance;
	logic         res_valid;
	logic         out_free;
	sfsw_result_t res;
	sfsw_result_t res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_address_q    <= RX_ADDRESS_RST;
			reply_address_q <= REPLY_ADDRESS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RX_ADDRESS:    rx_address_q    <= cfg_data;
				CFG_REPLY_ADDRESS: reply_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the byte while its result cannot be stored
	assign advance  = valid_s1 && (out_free || !res_valid);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	sfsw_frame_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.byte_in       (byte_s1),
		.rx_address    (rx_address_q),
		.reply_address (reply_address_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	sfsw_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res_in    (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out)
	);

	assign event_res     = res_out.ev;
	assign payload_byte  = res_out.payload;
	assign reply_valid   = res_out.reply_valid;
	assign reply_control = res_out.reply_control;
	assign reply_bcc     = res_out.reply_bcc;
	assign seq_now       = res_out.seq_now;

endmodule
